### rtl/lif_pkg.sv
package lif_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int WIDE_W    = 64;

  // Sideband data that rides alongside the dividers.
  typedef struct packed {
    logic signed [COORD_W-1:0] ap;
    logic signed [COORD_W-1:0] aq;
    logic signed [COORD_W-1:0] cp;
    logic signed [COORD_W-1:0] cq;
    logic signed [WIDE_W-1:0]  c1;
    logic                      swap;   // slopes taken as dx/dy
    logic                      fail;
  } side_t;

endpackage

### rtl/lif_div.sv
module lif_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [lif_pkg::WIDE_W-1:0]   dividend,
  input  logic [lif_pkg::WIDE_W-1:0]   divisor,
  input  lif_pkg::side_t               side_in,
  output logic                         out_valid,
  output logic [lif_pkg::WIDE_W-1:0]   quotient,
  output lif_pkg::side_t               side_out
);
  import lif_pkg::*;

  logic              vld  [WIDE_W+1];
  logic [WIDE_W-1:0] rem  [WIDE_W+1];
  logic [WIDE_W-1:0] dq   [WIDE_W+1];
  logic [WIDE_W-1:0] dv   [WIDE_W+1];
  logic              neg  [WIDE_W+1];
  logic              dz   [WIDE_W+1];
  side_t             side [WIDE_W+1];

  logic [WIDE_W:0]   sh    [WIDE_W];
  logic              ge    [WIDE_W];
  logic [WIDE_W:0]   sub   [WIDE_W];
  logic [WIDE_W-1:0] rem_n [WIDE_W];
  logic [WIDE_W-1:0] dq_n  [WIDE_W];

  // one restoring step per stage, quotient bits shift into dq
  always_comb begin
    for (int i = 0; i < WIDE_W; i++) begin
      sh[i]    = {rem[i], dq[i][WIDE_W-1]};
      sub[i]   = sh[i] - {1'b0, dv[i]};
      ge[i]    = !sub[i][WIDE_W];
      rem_n[i] = ge[i] ? sub[i][WIDE_W-1:0] : sh[i][WIDE_W-1:0];
      dq_n[i]  = {dq[i][WIDE_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= WIDE_W; i++) vld[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 0; i < WIDE_W; i++) vld[i+1] <= vld[i];
      out_valid <= vld[WIDE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= '0;
      dq[0]   <= dividend[WIDE_W-1] ? (WIDE_W'(0) - dividend) : dividend;
      dv[0]   <= divisor[WIDE_W-1]  ? (WIDE_W'(0) - divisor)  : divisor;
      neg[0]  <= dividend[WIDE_W-1] ^ divisor[WIDE_W-1];
      dz[0]   <= (divisor == '0);
      side[0] <= side_in;
      for (int i = 0; i < WIDE_W; i++) begin
        rem[i+1]  <= rem_n[i];
        dq[i+1]   <= dq_n[i];
        dv[i+1]   <= dv[i];
        neg[i+1]  <= neg[i];
        dz[i+1]   <= dz[i];
        side[i+1] <= side[i];
      end
      if (dz[WIDE_W]) quotient <= '0;
      else if (neg[WIDE_W]) quotient <= WIDE_W'(0) - dq[WIDE_W];
      else quotient <= dq[WIDE_W];
      side_out <= side[WIDE_W];
    end
  end

endmodule

### rtl/lif_front.sv
module lif_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic signed [lif_pkg::COORD_W-1:0]  ax,
  input  logic signed [lif_pkg::COORD_W-1:0]  ay,
  input  logic signed [lif_pkg::COORD_W-1:0]  bx,
  input  logic signed [lif_pkg::COORD_W-1:0]  by,
  input  logic signed [lif_pkg::COORD_W-1:0]  cx,
  input  logic signed [lif_pkg::COORD_W-1:0]  cy,
  input  logic signed [lif_pkg::COORD_W-1:0]  dx,
  input  logic signed [lif_pkg::COORD_W-1:0]  dy,
  output logic                                out_valid,
  output logic [lif_pkg::WIDE_W-1:0]          num1,
  output logic [lif_pkg::WIDE_W-1:0]          den1,
  output logic [lif_pkg::WIDE_W-1:0]          num2,
  output logic [lif_pkg::WIDE_W-1:0]          den2,
  output lif_pkg::side_t                      side
);
  import lif_pkg::*;

  logic signed [COORD_W-1:0] rax, ray, rbx, rby, rcx, rcy, rdx, rdy;
  logic signed [COORD_W-1:0] ap, aq, bp, bq, cp, cq, dp, dq;
  logic [COORD_W-1:0] d1q, d1p, d2q, d2p;
  logic horiz;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rax <= ax; ray <= ay; rbx <= bx; rby <= by;
      rcx <= cx; rcy <= cy; rdx <= dx; rdy <= dy;
    end
  end

  always_comb begin
    horiz = (ray == rby) || (rcy == rdy);
    ap = horiz ? rax : ray;  aq = horiz ? ray : rax;
    bp = horiz ? rbx : rby;  bq = horiz ? rby : rbx;
    cp = horiz ? rcx : rcy;  cq = horiz ? rcy : rcx;
    dp = horiz ? rdx : rdy;  dq = horiz ? rdy : rdx;
    d1q = bq - aq;
    d1p = bp - ap;
    d2q = dq - cq;
    d2p = dp - cp;
    num1 = {{(WIDE_W-COORD_W){d1q[COORD_W-1]}}, d1q} << FRAC_BITS;
    den1 = {{(WIDE_W-COORD_W){d1p[COORD_W-1]}}, d1p};
    num2 = {{(WIDE_W-COORD_W){d2q[COORD_W-1]}}, d2q} << FRAC_BITS;
    den2 = {{(WIDE_W-COORD_W){d2p[COORD_W-1]}}, d2p};
    side.ap   = ap;
    side.aq   = aq;
    side.cp   = cp;
    side.cq   = cq;
    side.c1   = '0;
    side.swap = !horiz;
    // horizontal line mixed with a vertical one
    side.fail = horiz && ((rax == rbx) || (rcx == rdx));
  end

endmodule

### rtl/lif_solve.sv
module lif_solve (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [lif_pkg::WIDE_W-1:0]  c1,
  input  logic [lif_pkg::WIDE_W-1:0]  c2,
  input  lif_pkg::side_t              side_in,
  output logic                        out_valid,
  output logic [lif_pkg::WIDE_W-1:0]  dividend,
  output logic [lif_pkg::WIDE_W-1:0]  divisor,
  output lif_pkg::side_t              side_out
);
  import lif_pkg::*;

  logic v1, v2;
  side_t s1, s2;
  side_t s1_next, side_out_next;
  logic signed [WIDE_W-1:0] p1lo, p1hi, p2lo, p2hi;
  logic [WIDE_W-1:0] dlt1, dlt2;
  logic eq1, eq2;
  logic [COORD_W-1:0] dcq1, dcq2;
  logic signed [WIDE_W-1:0] pr1, pr2;
  logic signed [WIDE_W-1:0] diff, num;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; out_valid <= v2;
    end
  end

  always_comb begin
    diff = pr1 - pr2;
    num  = $signed({{(WIDE_W-COORD_W){dcq2[COORD_W-1]}}, dcq2}) + (diff >>> FRAC_BITS);
    s1_next       = side_in;
    s1_next.c1    = c1;
    side_out_next      = s2;
    side_out_next.fail = s2.fail || eq2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // split each wide product into halves of the slope
      p1lo <= $signed(side_in.ap) * $signed({1'b0, c1[COORD_W-1:0]});
      p1hi <= $signed(side_in.ap) * $signed(c1[WIDE_W-1:COORD_W]);
      p2lo <= $signed(side_in.cp) * $signed({1'b0, c2[COORD_W-1:0]});
      p2hi <= $signed(side_in.cp) * $signed(c2[WIDE_W-1:COORD_W]);
      dlt1 <= c1 - c2;
      eq1  <= (c1 == c2);
      dcq1 <= side_in.cq - side_in.aq;
      s1   <= s1_next;

      pr1  <= p1lo + {p1hi[COORD_W-1:0], {COORD_W{1'b0}}};
      pr2  <= p2lo + {p2hi[COORD_W-1:0], {COORD_W{1'b0}}};
      dlt2 <= dlt1;
      eq2  <= eq1;
      dcq2 <= dcq1;
      s2   <= s1;

      dividend <= num << FRAC_BITS;
      divisor  <= dlt2;
      side_out <= side_out_next;
    end
  end

endmodule

### rtl/lif_back.sv
module lif_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [lif_pkg::WIDE_W-1:0]          quotient,
  input  lif_pkg::side_t                      side_in,
  output logic                                out_valid,
  output logic signed [lif_pkg::COORD_W-1:0]  cross_x,
  output logic signed [lif_pkg::COORD_W-1:0]  cross_y,
  output logic                                found
);
  import lif_pkg::*;

  logic v1, v2;
  side_t s1, s2;
  logic [COORD_W-1:0] p1, p2, t1;
  logic signed [WIDE_W-1:0] mlo, mhi;
  logic signed [WIDE_W-1:0] msum;
  logic [COORD_W-1:0] rq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; out_valid <= v2;
    end
  end

  always_comb begin
    msum = mlo + {mhi[COORD_W-1:0], {COORD_W{1'b0}}};
    rq   = s2.aq + COORD_W'(msum >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= quotient[COORD_W-1:0];
      t1 <= quotient[COORD_W-1:0] - side_in.ap;
      s1 <= side_in;

      mlo <= $signed(t1) * $signed({1'b0, s1.c1[COORD_W-1:0]});
      mhi <= $signed(t1) * $signed(s1.c1[WIDE_W-1:COORD_W]);
      p2  <= p1;
      s2  <= s1;

      found <= !s2.fail;
      if (s2.fail) begin
        cross_x <= '0;
        cross_y <= '0;
      end else if (s2.swap) begin
        cross_x <= rq;
        cross_y <= p2;
      end else begin
        cross_x <= p2;
        cross_y <= rq;
      end
    end
  end

endmodule

### rtl/line_intersection_fixed_point.sv
// channel | handshake           | payload
// in      | in_valid, in_stall  | first_*/second_* start/end x,y (s16.16)
// out     | out_valid, out_stall| cross_x, cross_y, found
//
// One item per cycle unless stalled. Stages: input register, 66-stage
// restoring dividers (two slope, then one intersection), three multiply
// stages each. The dividers set the depth, one quotient bit per stage.
// Reset (rst, synchronous) clears only the valid bits along the pipe.
// A held result stalls the whole pipe; in_stall follows out_stall then.
module line_intersection_fixed_point (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lif_pkg::COORD_W-1:0]  first_start_x,
  input  logic signed [lif_pkg::COORD_W-1:0]  first_start_y,
  input  logic signed [lif_pkg::COORD_W-1:0]  first_end_x,
  input  logic signed [lif_pkg::COORD_W-1:0]  first_end_y,
  input  logic signed [lif_pkg::COORD_W-1:0]  second_start_x,
  input  logic signed [lif_pkg::COORD_W-1:0]  second_start_y,
  input  logic signed [lif_pkg::COORD_W-1:0]  second_end_x,
  input  logic signed [lif_pkg::COORD_W-1:0]  second_end_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lif_pkg::COORD_W-1:0]  cross_x,
  output logic signed [lif_pkg::COORD_W-1:0]  cross_y,
  output logic                                found
);
  import lif_pkg::*;

  logic adv;
  logic f_valid, s_valid, m_valid, q_valid;
  logic [WIDE_W-1:0] num1, den1, num2, den2, c1, c2, mnum, mden, quo;
  side_t f_side, s_side, m_side, q_side;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  lif_front u_front (
    .clk, .rst, .adv, .in_valid,
    .ax(first_start_x), .ay(first_start_y), .bx(first_end_x), .by(first_end_y),
    .cx(second_start_x), .cy(second_start_y), .dx(second_end_x), .dy(second_end_y),
    .out_valid(f_valid), .num1, .den1, .num2, .den2, .side(f_side)
  );

  lif_div u_slope1 (
    .clk, .rst, .adv, .in_valid(f_valid), .dividend(num1), .divisor(den1),
    .side_in(f_side), .out_valid(s_valid), .quotient(c1), .side_out(s_side)
  );

  lif_div u_slope2 (
    .clk, .rst, .adv, .in_valid(f_valid), .dividend(num2), .divisor(den2),
    .side_in(f_side), .out_valid(), .quotient(c2), .side_out()
  );

  lif_solve u_solve (
    .clk, .rst, .adv, .in_valid(s_valid), .c1, .c2, .side_in(s_side),
    .out_valid(m_valid), .dividend(mnum), .divisor(mden), .side_out(m_side)
  );

  lif_div u_cross (
    .clk, .rst, .adv, .in_valid(m_valid), .dividend(mnum), .divisor(mden),
    .side_in(m_side), .out_valid(q_valid), .quotient(quo), .side_out(q_side)
  );

  lif_back u_back (
    .clk, .rst, .adv, .in_valid(q_valid), .quotient(quo), .side_in(q_side),
    .out_valid, .cross_x, .cross_y, .found
  );

endmodule
